[src/bcs_pkg.sv]
// bcs_pkg: types, constants and reply byte functions for the bus command slave.
// Used by bus_command_slave in src and by both sim files; depends on nothing.
package bcs_pkg;

  localparam int REPLY_DEPTH_DEF = 64;
  localparam int REG_COUNT_DEF   = 16;

  localparam logic [7:0] REG_RESET_VAL   = 8'd65;
  localparam logic [7:0] REPLY_RESET_VAL = 8'd0;
  localparam logic [7:0] WRITE_MARK      = 8'd9;
  localparam logic [7:0] ID_LEN          = 8'd32;

  localparam logic [8*32-1:0] ID_TEXT = "I am temp/power/water/start PIC.";

  // position in the reply store, wide enough for the identify reply
  localparam int POS_W = 6;

  localparam logic [7:0] CMD_PING   = 8'd0;
  localparam logic [7:0] CMD_IDENT  = 8'd1;
  localparam logic [7:0] CMD_RD_REG = 8'd2;
  localparam logic [7:0] CMD_WR_REG = 8'd3;
  localparam logic [7:0] CMD_DEPTH  = 8'd5;
  localparam logic [7:0] CMD_TEMP   = 8'd15;
  localparam logic [7:0] CMD_STATUS = 8'd16;
  localparam logic [7:0] CMD_KILL   = 8'd17;

  typedef enum logic [1:0] {
    MODE_TOP    = 2'd0,
    MODE_RD_ARG = 2'd1,
    MODE_WR_ARG = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    RK_NONE,
    RK_PING,
    RK_IDENT,
    RK_DEPTH,
    RK_TEMP,
    RK_STAT,
    RK_REG
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_REG_RD,
    ST_FILL,
    ST_RD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  data_byte;
    logic [6:0]  board_status;
    logic [15:0] depth_value;
    logic [7:0]  temp_0;
    logic [7:0]  temp_1;
    logic [7:0]  temp_2;
    logic [7:0]  temp_3;
    logic [7:0]  temp_4;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       kill_out;
    logic       underrun;
  } rsp_t;

  function automatic kind_t cmd_kind(input logic [7:0] cmd);
    kind_t k;
    priority case (cmd)
      CMD_PING:   k = RK_PING;
      CMD_IDENT:  k = RK_IDENT;
      CMD_DEPTH:  k = RK_DEPTH;
      CMD_TEMP:   k = RK_TEMP;
      CMD_STATUS: k = RK_STAT;
      default:    k = RK_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [POS_W-1:0] first_pos(input kind_t k);
    return (k == RK_NONE) ? POS_W'(1) : POS_W'(0);
  endfunction

  function automatic logic [POS_W-1:0] last_pos(input kind_t k);
    logic [POS_W-1:0] p;
    unique case (k)
      RK_IDENT: p = POS_W'(33);
      RK_DEPTH: p = POS_W'(2);
      RK_TEMP:  p = POS_W'(5);
      default:  p = POS_W'(1);
    endcase
    return p;
  endfunction

  // final value of reply byte pos after a write access of this kind
  function automatic logic [7:0] reply_byte(input kind_t k, input logic [POS_W-1:0] pos,
                                            input req_t r, input logic [7:0] regval);
    logic [7:0] b;
    int         sh;
    sh = 8 * (32 - int'(pos));
    b  = WRITE_MARK;
    unique case (k)
      RK_NONE: b = WRITE_MARK;
      RK_PING: b = (pos == '0) ? 8'd0 : WRITE_MARK;
      RK_IDENT: begin
        if (pos == '0) begin
          b = ID_LEN;
        end else if (pos == POS_W'(33)) begin
          b = 8'd0;
        end else begin
          b = ID_TEXT[sh +: 8];
        end
      end
      RK_DEPTH: begin
        priority case (pos)
          POS_W'(0): b = 8'd2;
          POS_W'(1): b = r.depth_value[15:8];
          default:   b = r.depth_value[7:0];
        endcase
      end
      RK_TEMP: begin
        priority case (pos)
          POS_W'(0): b = 8'd5;
          POS_W'(1): b = r.temp_0;
          POS_W'(2): b = r.temp_1;
          POS_W'(3): b = r.temp_2;
          POS_W'(4): b = r.temp_3;
          default:   b = r.temp_4;
        endcase
      end
      RK_STAT: b = (pos == '0) ? 8'd1 : {1'b0, r.board_status};
      RK_REG:  b = (pos == '0) ? 8'd1 : regval;
      default: b = WRITE_MARK;
    endcase
    return b;
  endfunction

endpackage

[src/bcs_mem.sv]
// bcs_mem: byte-wide synchronous memory, one write and one registered read port.
// Per-entry valid bits give the reset value for entries never written. Uses no package.
module bcs_mem #(
  parameter int         DEPTH   = 64,
  parameter logic [7:0] RST_VAL = 8'd0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [7:0]       mem_q;
  logic             vld_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
    vld_q <= valid[raddr];
  end

  assign rdata = vld_q ? mem_q : RST_VAL;

endmodule

[src/bcs_mod.sv]
// bcs_mod: byte modulo a constant register count through a 256-entry constant table.
// Result is registered; done follows start in the next cycle. Uses no package.
module bcs_mod #(
  parameter int N = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [7:0]           din,
  output logic                 done,
  output logic [$clog2(N)-1:0] dout
);

  localparam int W = $clog2(N);

  logic [W-1:0] mod_tab [256];

  for (genvar g = 0; g < 256; g++) begin : g_tab
    assign mod_tab[g] = W'(g % N);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dout <= mod_tab[din];
    end
  end

endmodule

[src/bus_command_slave.sv]
// bus_command_slave: byte-wide command slave with reply store and register file.
// Depends on bcs_pkg, bcs_mem (reply store, register file) and bcs_mod.
//
//   channel  valid      ready      payload              direction
//   request  req_valid  req_ready  req_data (req_t)     in
//   response rsp_valid  rsp_ready  rsp_data (rsp_t)     out
//
// Read request: ST_RD (registered reply store read), then ST_DONE; once past the end, ST_DONE only.
// Write request: ST_FILL writes the reply store through its write port, one byte a cycle
// (identify fills 34 bytes), then ST_DONE; an index argument adds ST_MOD for the modulo lookup,
// a register read also ST_REG_RD.
// Reset is synchronous; valid bits clear both memories at once.
// A new request is taken while the previous response waits in the output register.
module bus_command_slave #(
  parameter int REPLY_DEPTH = bcs_pkg::REPLY_DEPTH_DEF,
  parameter int REG_COUNT   = bcs_pkg::REG_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bcs_pkg::req_t  req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bcs_pkg::rsp_t  rsp_data
);

  localparam int RAW = $clog2(REPLY_DEPTH);
  localparam int RIW = $clog2(REPLY_DEPTH + 1);
  localparam int GAW = $clog2(REG_COUNT);
  localparam int PW  = bcs_pkg::POS_W;

  bcs_pkg::state_t state, state_next;
  bcs_pkg::mode_t  mode, mode_next;
  bcs_pkg::kind_t  kind, kind_next;
  bcs_pkg::req_t   req_q, req_q_next;
  bcs_pkg::rsp_t   rsp_next;
  logic            arg_count, arg_count_next;
  logic [GAW-1:0]  reg_index, reg_index_next;
  logic [RIW-1:0]  reply_index, reply_index_next;
  logic            kill_latch, kill_latch_next;
  logic            pend_rd, pend_rd_next;
  logic [PW-1:0]   pos, pos_next;
  logic [7:0]      regval, regval_next;
  logic [7:0]      res_data, res_data_next;
  logic            res_under, res_under_next;
  logic            rsp_valid_next;

  logic            mod_start, mod_done;
  logic [GAW-1:0]  mod_out;
  logic            reg_we, reply_we;
  logic [7:0]      reg_rdata, reply_rdata;

  bcs_mod #(.N(REG_COUNT)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .din   (req_data.data_byte),
    .done  (mod_done),
    .dout  (mod_out)
  );

  bcs_mem #(.DEPTH(REG_COUNT), .RST_VAL(bcs_pkg::REG_RESET_VAL)) u_reg_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (reg_we),
    .waddr (reg_index),
    .wdata (req_data.data_byte),
    .raddr (mod_out),
    .rdata (reg_rdata)
  );

  bcs_mem #(.DEPTH(REPLY_DEPTH), .RST_VAL(bcs_pkg::REPLY_RESET_VAL)) u_reply_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (reply_we),
    .waddr (RAW'(pos)),
    .wdata (bcs_pkg::reply_byte(kind, pos, req_q, regval)),
    .raddr (reply_index[RAW-1:0]),
    .rdata (reply_rdata)
  );

  assign req_ready = (state == bcs_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bcs_pkg::ST_IDLE;
      mode        <= bcs_pkg::MODE_TOP;
      arg_count   <= 1'b0;
      reg_index   <= '0;
      reply_index <= '0;
      kill_latch  <= 1'b0;
      pend_rd     <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      mode        <= mode_next;
      arg_count   <= arg_count_next;
      reg_index   <= reg_index_next;
      reply_index <= reply_index_next;
      kill_latch  <= kill_latch_next;
      pend_rd     <= pend_rd_next;
      rsp_valid   <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind      <= kind_next;
    req_q     <= req_q_next;
    pos       <= pos_next;
    regval    <= regval_next;
    res_data  <= res_data_next;
    res_under <= res_under_next;
    rsp_data  <= rsp_next;
  end

  always_comb begin
    state_next       = state;
    mode_next        = mode;
    kind_next        = kind;
    req_q_next       = req_q;
    arg_count_next   = arg_count;
    reg_index_next   = reg_index;
    reply_index_next = reply_index;
    kill_latch_next  = kill_latch;
    pend_rd_next     = pend_rd;
    pos_next         = pos;
    regval_next      = regval;
    res_data_next    = res_data;
    res_under_next   = res_under;
    rsp_next         = rsp_data;
    rsp_valid_next   = rsp_valid && !rsp_ready;
    mod_start        = 1'b0;
    reg_we           = 1'b0;
    reply_we         = 1'b0;

    unique case (state)
      bcs_pkg::ST_IDLE: begin
        if (req_valid) begin
          req_q_next = req_data;
          if (req_data.req_type) begin
            if (reply_index < RIW'(REPLY_DEPTH)) begin
              res_under_next = 1'b0;
              state_next     = bcs_pkg::ST_RD;
            end else begin
              res_data_next  = 8'd0;
              res_under_next = 1'b1;
              state_next     = bcs_pkg::ST_DONE;
            end
          end else begin
            reply_index_next = '0;
            res_data_next    = 8'd0;
            res_under_next   = 1'b0;
            pend_rd_next     = 1'b0;
            if (mode == bcs_pkg::MODE_RD_ARG) begin
              mode_next      = bcs_pkg::MODE_TOP;
              arg_count_next = 1'b0;
              pend_rd_next   = 1'b1;
              mod_start      = 1'b1;
              state_next     = bcs_pkg::ST_MOD;
            end else if (mode == bcs_pkg::MODE_WR_ARG && !arg_count) begin
              arg_count_next = 1'b1;
              mod_start      = 1'b1;
              state_next     = bcs_pkg::ST_MOD;
            end else if (mode == bcs_pkg::MODE_WR_ARG) begin
              reg_we         = 1'b1;
              arg_count_next = 1'b0;
              mode_next      = bcs_pkg::MODE_TOP;
              kind_next      = bcs_pkg::RK_NONE;
              pos_next       = bcs_pkg::first_pos(bcs_pkg::RK_NONE);
              state_next     = bcs_pkg::ST_FILL;
            end else begin
              mode_next = bcs_pkg::MODE_TOP;
              if (req_data.data_byte == bcs_pkg::CMD_RD_REG) begin
                mode_next = bcs_pkg::MODE_RD_ARG;
              end else if (req_data.data_byte == bcs_pkg::CMD_WR_REG) begin
                mode_next      = bcs_pkg::MODE_WR_ARG;
                arg_count_next = 1'b0;
              end else if (req_data.data_byte == bcs_pkg::CMD_KILL) begin
                kill_latch_next = 1'b1;
              end
              kind_next  = bcs_pkg::cmd_kind(req_data.data_byte);
              pos_next   = bcs_pkg::first_pos(bcs_pkg::cmd_kind(req_data.data_byte));
              state_next = bcs_pkg::ST_FILL;
            end
          end
        end
      end
      bcs_pkg::ST_MOD: begin
        if (mod_done) begin
          if (pend_rd) begin
            state_next = bcs_pkg::ST_REG_RD;
          end else begin
            reg_index_next = mod_out;
            kind_next      = bcs_pkg::RK_NONE;
            pos_next       = bcs_pkg::first_pos(bcs_pkg::RK_NONE);
            state_next     = bcs_pkg::ST_FILL;
          end
        end
      end
      bcs_pkg::ST_REG_RD: begin
        regval_next = reg_rdata;
        kind_next   = bcs_pkg::RK_REG;
        pos_next    = bcs_pkg::first_pos(bcs_pkg::RK_REG);
        state_next  = bcs_pkg::ST_FILL;
      end
      bcs_pkg::ST_FILL: begin
        reply_we = 1'b1;
        if (pos == bcs_pkg::last_pos(kind)) begin
          state_next = bcs_pkg::ST_DONE;
        end else begin
          pos_next = pos + PW'(1);
        end
      end
      bcs_pkg::ST_RD: begin
        res_data_next    = reply_rdata;
        reply_index_next = reply_index + RIW'(1);
        state_next       = bcs_pkg::ST_DONE;
      end
      bcs_pkg::ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next     = 1'b1;
          rsp_next.read_data = res_data;
          rsp_next.kill_out  = kill_latch;
          rsp_next.underrun  = res_under;
          state_next         = bcs_pkg::ST_IDLE;
        end
      end
      default: state_next = bcs_pkg::ST_IDLE;
    endcase
  end

endmodule

[sim/bcs_checker.sv]
// bcs_checker: watches both channels of bus_command_slave, predicts each reply
// from its own copy of the slave state and compares it field by field.
// Depends on bcs_pkg for the payload structs, command codes and constants.
module bcs_checker
  import bcs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  input  logic  req_ready,
  input  req_t  req_data,
  input  logic  rsp_valid,
  input  logic  rsp_ready,
  input  rsp_t  rsp_data,
  output int    mismatch_count,
  output int    replies_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEL_W = $clog2(REG_COUNT_DEF);

  mode_t            bus_st;
  logic             arg_seen;
  logic [SEL_W-1:0] wr_sel;
  logic [7:0]       regs [REG_COUNT_DEF];
  logic [7:0]       reply_buf [REPLY_DEPTH_DEF];
  logic [6:0]       rd_ptr;
  logic             killed;
  rsp_t             reply_q [$];

  function automatic rsp_t slave_reply(input req_t r);
    rsp_t       o;
    logic [7:0] b;
    int         k;
    o = '0;
    b = r.data_byte;
    if (!r.req_type) begin
      rd_ptr = '0;
      reply_buf[1] = WRITE_MARK;
      case (bus_st)
        MODE_RD_ARG: begin
          bus_st = MODE_TOP;
          arg_seen = 1'b0;
          reply_buf[0] = 8'd1;
          reply_buf[1] = regs[b % REG_COUNT_DEF];
        end
        MODE_WR_ARG: begin
          if (!arg_seen) begin
            wr_sel = SEL_W'(b % REG_COUNT_DEF);
            arg_seen = 1'b1;
          end else begin
            regs[wr_sel] = b;
            arg_seen = 1'b0;
            bus_st = MODE_TOP;
          end
        end
        default: begin
          bus_st = MODE_TOP;
          case (b)
            CMD_PING: reply_buf[0] = 8'd0;
            CMD_IDENT: begin
              for (k = 0; k < 32; k++) reply_buf[k+1] = ID_TEXT[8*(31-k) +: 8];
              reply_buf[33] = 8'd0;
              reply_buf[0] = ID_LEN;
            end
            CMD_RD_REG: begin
              bus_st = MODE_RD_ARG;
              arg_seen = 1'b0;
            end
            CMD_WR_REG: begin
              bus_st = MODE_WR_ARG;
              arg_seen = 1'b0;
            end
            CMD_DEPTH: begin
              reply_buf[0] = 8'd2;
              reply_buf[1] = r.depth_value[15:8];
              reply_buf[2] = r.depth_value[7:0];
            end
            CMD_TEMP: begin
              reply_buf[0] = 8'd5;
              reply_buf[1] = r.temp_0;
              reply_buf[2] = r.temp_1;
              reply_buf[3] = r.temp_2;
              reply_buf[4] = r.temp_3;
              reply_buf[5] = r.temp_4;
            end
            CMD_STATUS: begin
              reply_buf[0] = 8'd1;
              reply_buf[1] = {1'b0, r.board_status};
            end
            CMD_KILL: killed = 1'b1;
            default: ;
          endcase
        end
      endcase
    end else if (rd_ptr < REPLY_DEPTH_DEF) begin
      o.read_data = reply_buf[rd_ptr];
      rd_ptr++;
    end else begin
      o.underrun = 1'b1;
    end
    o.kill_out = killed;
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (rst) begin
      bus_st = MODE_TOP;
      arg_seen = 1'b0;
      wr_sel = '0;
      for (int i = 0; i < REG_COUNT_DEF; i++) regs[i] = REG_RESET_VAL;
      for (int i = 0; i < REPLY_DEPTH_DEF; i++) reply_buf[i] = REPLY_RESET_VAL;
      rd_ptr = '0;
      killed = 1'b0;
      reply_q.delete();
      mismatch_count = 0;
    end else begin
      // replies lag their requests, so retire before queueing
      if (rsp_valid && rsp_ready) begin
        got = rsp_data;
        if (reply_q.size() == 0) begin
          $display("%0t: reply with none pending: data %02h kill %b underrun %b",
                   $time, got.read_data, got.kill_out, got.underrun);
          mismatch_count++;
        end else begin
          want = reply_q.pop_front();
          if (got.read_data !== want.read_data) begin
            $display("%0t: read_data expected %02h got %02h",
                     $time, want.read_data, got.read_data);
            mismatch_count++;
          end
          if (got.kill_out !== want.kill_out) begin
            $display("%0t: kill_out expected %b got %b", $time, want.kill_out, got.kill_out);
            mismatch_count++;
          end
          if (got.underrun !== want.underrun) begin
            $display("%0t: underrun expected %b got %b", $time, want.underrun, got.underrun);
            mismatch_count++;
          end
        end
      end
      if (req_valid && req_ready) reply_q.push_back(slave_reply(req_data));
    end
    replies_due = reply_q.size();
  end

endmodule

[sim/tb_bus_command_slave.sv]
// tb_bus_command_slave: drives requests into bus_command_slave with bursty
// timing and a stalling reply side; bcs_checker predicts and compares.
// Depends on bcs_pkg, bus_command_slave and bcs_checker.
module tb_bus_command_slave;
  import bcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_READ    = 1'b1;
  localparam int   ITEM_TARGET = 700;
  localparam int   QUIET_LIMIT = 2000;
  localparam int   SETTLE_CYC  = 50;

  typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_SPARSE, RDY_BURSTY} rdy_style_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data  = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;

  int mismatch_count;
  int replies_due;
  int sent;
  int burst_left;
  int quiet_cycles;
  int rdy_phase;
  rdy_style_t rdy_style;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bus_command_slave u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  bcs_checker u_chk (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req_data       (req_data),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp_data       (rsp_data),
    .mismatch_count (mismatch_count),
    .replies_due    (replies_due)
  );

  // reply side: rsp_ready follows a stall style picked at random from four
  always @(negedge clk) begin
    if (rdy_phase % 64 == 0) rdy_style = rdy_style_t'($urandom_range(0, 3));
    rdy_phase++;
    case (rdy_style)
      RDY_ALWAYS: rsp_ready <= 1'b1;
      RDY_RANDOM: rsp_ready <= ($urandom_range(0, 9) < 7);
      RDY_SPARSE: rsp_ready <= (rdy_phase % 4 == 0);
      default:    rsp_ready <= (rdy_phase % 32 >= 24);
    endcase
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("bus_command_slave verification failed");
      $finish;
    end
  end

  function automatic req_t make_req(input logic kind, input logic [7:0] b);
    req_t r;
    r.req_type     = kind;
    r.data_byte    = b;
    r.board_status = 7'($urandom);
    r.depth_value  = 16'($urandom);
    r.temp_0       = 8'($urandom);
    r.temp_1       = 8'($urandom);
    r.temp_2       = 8'($urandom);
    r.temp_3       = 8'($urandom);
    r.temp_4       = 8'($urandom);
    return r;
  endfunction

  // called and returns at a falling edge
  task automatic send(input req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (!req_ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (replies_due != 0);
  endtask

  initial begin
    req_t       r;
    int         seq_no;
    int         pick;
    int         n_rd;
    logic [7:0] cmd;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed requests
    send(make_req(REQ_READ, 8'hFF));
    send(make_req(REQ_WRITE, CMD_IDENT));
    repeat (2) send(make_req(REQ_READ, 8'h00));
    send(make_req(REQ_WRITE, CMD_PING));
    repeat (3) send(make_req(REQ_READ, 8'h00));  // third byte is stale identify text
    r = make_req(REQ_WRITE, CMD_DEPTH);
    r.depth_value = 16'hFFFF;
    send(r);
    repeat (3) send(make_req(REQ_READ, 8'h00));
    r = make_req(REQ_WRITE, CMD_TEMP);
    {r.temp_0, r.temp_1, r.temp_2, r.temp_3, r.temp_4} = '1;
    send(r);
    repeat (2) send(make_req(REQ_READ, 8'h00));
    r = make_req(REQ_WRITE, CMD_STATUS);
    r.board_status = 7'h7F;
    send(r);
    repeat (2) send(make_req(REQ_READ, 8'h00));
    send(make_req(REQ_WRITE, CMD_WR_REG));
    send(make_req(REQ_WRITE, 8'hFF));  // index wraps to the last register
    send(make_req(REQ_WRITE, 8'h00));
    send(make_req(REQ_WRITE, CMD_RD_REG));
    send(make_req(REQ_WRITE, 8'h0F));
    repeat (2) send(make_req(REQ_READ, 8'h00));
    send(make_req(REQ_WRITE, 8'hFF));  // unknown command
    repeat (2) send(make_req(REQ_READ, 8'h00));
    drain();

    seq_no = 0;
    while (sent < ITEM_TARGET) begin
      seq_no++;
      pick = $urandom_range(0, 99);
      n_rd = $urandom_range(0, 5);
      if (pick < 12) begin
        send(make_req(REQ_WRITE, CMD_RD_REG));
        send(make_req(REQ_WRITE, 8'($urandom)));
        n_rd = $urandom_range(0, 3);
      end else if (pick < 24) begin
        send(make_req(REQ_WRITE, CMD_WR_REG));
        send(make_req(REQ_WRITE, 8'($urandom)));
        send(make_req(REQ_WRITE, 8'($urandom)));
        n_rd = $urandom_range(0, 2);
      end else if (pick < 75) begin
        case ($urandom_range(0, 9))
          0, 1:    cmd = CMD_PING;
          2, 3:    cmd = CMD_IDENT;
          4, 5:    cmd = CMD_DEPTH;
          6, 7:    cmd = CMD_TEMP;
          default: cmd = CMD_STATUS;
        endcase
        if (cmd == CMD_IDENT && $urandom_range(0, 2) == 0) n_rd = $urandom_range(6, 36);
        send(make_req(REQ_WRITE, cmd));
      end else if (pick < 85) begin
        send(make_req(REQ_WRITE, 8'($urandom)));
      end else begin
        n_rd = 0;
        repeat ($urandom_range(1, 4)) send(make_req(1'($urandom), 8'($urandom)));
      end
      // now and then read past the end of the reply store
      if (seq_no % 50 == 25) n_rd = $urandom_range(REPLY_DEPTH_DEF + 1, REPLY_DEPTH_DEF + 6);
      repeat (n_rd) send(make_req(REQ_READ, 8'($urandom)));
      if (seq_no == 60) drain();
    end

    // kill latches, so it goes last
    send(make_req(REQ_WRITE, CMD_KILL));
    repeat (2) send(make_req(REQ_READ, 8'($urandom)));
    drain();
    repeat (SETTLE_CYC) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("bus_command_slave verification clean");
    end else begin
      $display("bus_command_slave verification failed");
    end
    $finish;
  end

endmodule
